// File: rtl/core/small_matrix_arithmetic_unit_defines.svh
// Assertion macros used by the checker file of the matrix arithmetic unit.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SMALL_MATRIX_ARITHMETIC_UNIT_DEFINES_SVH
`define SMALL_MATRIX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SMAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/smau_pkg.sv
// Shared types and constants of the small matrix arithmetic unit.
// No dependencies; the sequencer, datapath, top level and checker import this package.
package smau_pkg;

	localparam int IDX_BITS    = 3;   // row and column fields
	localparam int CNT_BITS    = 4;   // size registers
	localparam int IN_ELEM_W   = 16;  // Q8.8 input element
	localparam int VALUE_W     = 40;  // Q24.16 result
	localparam int FRAC_SHIFT  = 8;   // Q8.8 to Q24.16 alignment
	localparam int CFG_INDEX_W = 2;

	typedef enum logic [1:0] {
		ACT_WR_A    = 2'd0,
		ACT_WR_B    = 2'd1,
		ACT_COMPUTE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		OP_ADD       = 3'd0,
		OP_SUB       = 3'd1,
		OP_MUL       = 3'd2,
		OP_AT_MUL    = 3'd3,
		OP_MUL_BT    = 3'd4,
		OP_TRANSPOSE = 3'd5
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_A_ROWS = 2'd0,
		CFG_A_COLS = 2'd1,
		CFG_B_ROWS = 2'd2,
		CFG_B_COLS = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]                  action;
		logic [2:0]                  operation;
		logic [IDX_BITS-1:0]         row_index;
		logic [IDX_BITS-1:0]         col_index;
		logic signed [IN_ELEM_W-1:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]       out_row;
		logic [IDX_BITS-1:0]       out_col;
		logic signed [VALUE_W-1:0] out_value;
		logic                      is_last;
		logic                      size_error;
	} out_item_t;

	// Raw size registers as written
	typedef struct packed {
		logic [CNT_BITS-1:0] a_rows;
		logic [CNT_BITS-1:0] a_cols;
		logic [CNT_BITS-1:0] b_rows;
		logic [CNT_BITS-1:0] b_cols;
	} dims_t;

	// Control carried alongside each memory read through the pipeline
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic                err;
		logic                first;      // first inner step of an element
		logic                elem_done;  // last inner step of an element
		logic                last;       // last step of the compute item
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
	} ctl_t;

endpackage

// File: rtl/core/smau_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smau_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; hold data while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/core/smau_seq.sv
// Sequencer: accepts item beats, writes elements into the stores and walks
// the stores for a compute item. Depends on smau_pkg.
module smau_seq #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  smau_pkg::in_item_t                  item,
	input  smau_pkg::dims_t                     dims,
	input  logic                                adv,
	output logic                                a_we,
	output logic                                b_we,
	output logic [2*$clog2(MAX_DIM)-1:0]        waddr,
	output logic [ELEM_WIDTH-1:0]               wdata,
	output logic                                re,
	output logic [2*$clog2(MAX_DIM)-1:0]        a_raddr,
	output logic [2*$clog2(MAX_DIM)-1:0]        b_raddr,
	output smau_pkg::ctl_t                      ctl_s1
);

	import smau_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic             err_q;
	logic [IDX_W-1:0] rows_m1_q, cols_m1_q, inner_m1_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;

	logic [IDX_W-1:0] ar, ac, br, bc;
	logic [IDX_W-1:0] rows_m1, cols_m1, inner_m1;
	logic             size_ok;
	logic             accept, wr_ok;
	logic             at_k_end, at_j_end, at_i_end;
	ctl_t             issue;

	// Size register to its last index: zero counts as one, clamp at MAX_DIM
	function automatic logic [IDX_W-1:0] last_idx(input logic [CNT_BITS-1:0] r);
		logic [IDX_W-1:0] res;
		if (r == '0) begin
			res = '0;
		end else if (r > CNT_BITS'(MAX_DIM)) begin
			res = IDX_W'(MAX_DIM - 1);
		end else begin
			res = IDX_W'(r - CNT_BITS'(1));
		end
		return res;
	endfunction

	assign ar = last_idx(dims.a_rows);
	assign ac = last_idx(dims.a_cols);
	assign br = last_idx(dims.b_rows);
	assign bc = last_idx(dims.b_cols);

	// Check shapes and pick the result extent of the requested operation
	always_comb begin
		size_ok  = 1'b0;
		rows_m1  = '0;
		cols_m1  = '0;
		inner_m1 = '0;
		unique case (item.operation)
			OP_ADD, OP_SUB: begin
				size_ok = (ar == br) && (ac == bc);
				rows_m1 = ar;
				cols_m1 = ac;
			end
			OP_MUL: begin
				size_ok  = (ac == br);
				rows_m1  = ar;
				cols_m1  = bc;
				inner_m1 = ac;
			end
			OP_AT_MUL: begin
				size_ok  = (ar == br);
				rows_m1  = ac;
				cols_m1  = bc;
				inner_m1 = ar;
			end
			OP_MUL_BT: begin
				size_ok  = (ac == bc);
				rows_m1  = ar;
				cols_m1  = br;
				inner_m1 = ac;
			end
			OP_TRANSPOSE: begin
				size_ok = (ar == ac);
				rows_m1 = ac;
				cols_m1 = ar;
			end
			default: size_ok = 1'b0;
		endcase
		// an error gives a single step at position zero
		if (!size_ok) begin
			rows_m1  = '0;
			cols_m1  = '0;
			inner_m1 = '0;
		end
	end

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	// Element writes; drop out-of-range positions
	assign wr_ok = accept
		&& (CNT_BITS'(item.row_index) < CNT_BITS'(MAX_DIM))
		&& (CNT_BITS'(item.col_index) < CNT_BITS'(MAX_DIM));
	assign a_we  = wr_ok && (item.action == ACT_WR_A);
	assign b_we  = wr_ok && (item.action == ACT_WR_B);
	assign waddr = {item.row_index[IDX_W-1:0], item.col_index[IDX_W-1:0]};
	assign wdata = ELEM_WIDTH'(item.element_value);

	// Current step of the walk
	assign at_k_end = (k_q == inner_m1_q);
	assign at_j_end = (j_q == cols_m1_q);
	assign at_i_end = (i_q == rows_m1_q);

	always_comb begin
		issue.valid     = (state_q == ST_RUN);
		issue.op        = op_q;
		issue.err       = err_q;
		issue.first     = (k_q == '0);
		issue.elem_done = at_k_end;
		issue.last      = at_k_end && at_j_end && at_i_end;
		issue.row       = IDX_BITS'(i_q);
		issue.col       = IDX_BITS'(j_q);
	end

	// Store addresses for the current step
	always_comb begin
		case (op_q) inside
			OP_MUL: begin
				a_raddr = {i_q, k_q};
				b_raddr = {k_q, j_q};
			end
			OP_AT_MUL: begin
				a_raddr = {k_q, i_q};
				b_raddr = {k_q, j_q};
			end
			OP_MUL_BT: begin
				a_raddr = {i_q, k_q};
				b_raddr = {j_q, k_q};
			end
			OP_TRANSPOSE: begin
				a_raddr = {j_q, i_q};
				b_raddr = {j_q, i_q};
			end
			default: begin
				a_raddr = {i_q, j_q};
				b_raddr = {i_q, j_q};
			end
		endcase
	end

	assign re = adv && (state_q == ST_RUN);

	// Walk control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_ADD;
			err_q      <= 1'b0;
			rows_m1_q  <= '0;
			cols_m1_q  <= '0;
			inner_m1_q <= '0;
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.action == ACT_COMPUTE)) begin
						state_q    <= ST_RUN;
						op_q       <= op_t'(item.operation);
						err_q      <= !size_ok;
						rows_m1_q  <= rows_m1;
						cols_m1_q  <= cols_m1;
						inner_m1_q <= inner_m1;
						i_q        <= '0;
						j_q        <= '0;
						k_q        <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (issue.last) begin
							state_q <= ST_IDLE;
						end
						// advance k, then j, then i
						if (at_k_end) begin
							k_q <= '0;
							if (at_j_end) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
						end else begin
							k_q <= k_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Control travels with the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= issue;
		end
	end

endmodule

// File: rtl/core/smau_dp.sv
// Datapath: forms each term from the read elements, accumulates the inner
// sum and holds the result beat. Depends on smau_pkg.
module smau_dp #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  smau_pkg::ctl_t        ctl_s1,
	input  logic [ELEM_WIDTH-1:0] a_rdata,
	input  logic [ELEM_WIDTH-1:0] b_rdata,
	input  logic                  result_stall,
	output logic                  adv,
	output logic                  result_valid,
	output smau_pkg::out_item_t   result
);

	import smau_pkg::*;

	localparam int PROD_W = 2 * ELEM_WIDTH;
	localparam int EXT_W  = (PROD_W > VALUE_W) ? PROD_W : VALUE_W;

	logic signed [ELEM_WIDTH-1:0] a_s, b_s;
	logic signed [VALUE_W-1:0]    a_ext, b_ext;
	logic signed [PROD_W-1:0]     prod;
	logic signed [EXT_W-1:0]      prod_ext;
	logic signed [VALUE_W-1:0]    term;
	logic signed [VALUE_W-1:0]    term_s2;
	logic signed [VALUE_W-1:0]    acc_q;
	logic signed [VALUE_W-1:0]    acc_next;
	ctl_t                         ctl_s2;
	logic                         result_valid_q;
	out_item_t                    result_q;

	assign adv = !result_valid_q || !result_stall;

	assign a_s      = signed'(a_rdata);
	assign b_s      = signed'(b_rdata);
	assign a_ext    = VALUE_W'(a_s);
	assign b_ext    = VALUE_W'(b_s);
	assign prod     = a_s * b_s;
	assign prod_ext = EXT_W'(prod);

	// Select the term for this step
	always_comb begin
		case (ctl_s1.op) inside
			OP_ADD:                       term = (a_ext + b_ext) <<< FRAC_SHIFT;
			OP_SUB:                       term = (a_ext - b_ext) <<< FRAC_SHIFT;
			OP_MUL, OP_AT_MUL, OP_MUL_BT: term = VALUE_W'(prod_ext);
			OP_TRANSPOSE:                 term = a_ext <<< FRAC_SHIFT;
			default:                      term = '0;
		endcase
		if (ctl_s1.err) begin
			term = '0;
		end
	end

	// Term stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s2 <= term;
		end
	end

	// Accumulate; restart on the first inner step
	assign acc_next = (ctl_s2.first ? '0 : acc_q) + term_s2;

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid) begin
			acc_q <= acc_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= ctl_s2.valid && ctl_s2.elem_done;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid && ctl_s2.elem_done) begin
			result_q.out_row    <= ctl_s2.row;
			result_q.out_col    <= ctl_s2.col;
			result_q.out_value  <= acc_next;
			result_q.is_last    <= ctl_s2.last;
			result_q.size_error <= ctl_s2.err;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: rtl/core/small_matrix_arithmetic_unit.sv
// Small matrix arithmetic unit: two element stores, sequencer and datapath.
// Depends on smau_pkg, smau_ram, smau_seq and smau_dp.
//
// Item channel (item_valid / item_stall / item): action 0 or 1 writes one
// element of A or B. Action 2 starts a compute; item_stall then stays high
// while the stores are walked, one store read per cycle while the result
// channel does not stall: rows*cols steps for add, subtract and transpose,
// rows*cols*inner steps for the three products, a single step for a size
// error. The single read port of each store sets this rate.
// Result channel (result_valid / result_stall / result): elements come out in
// row-major order, is_last on the final one. Each step passes the store read
// register and the term stage before its sum reaches the result register.
// When the receiver stalls, the held result does not change and the walk
// pauses; item beats are taken again as soon as the last read of a compute
// has issued. Size registers are written through cfg_we / cfg_index /
// cfg_data; the user must write them only while idle, as the block itself
// does not enforce this. Reset sets all sizes to MAX_DIM and empties the
// pipeline; store contents are undefined until written.
module small_matrix_arithmetic_unit #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  smau_pkg::in_item_t                   item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output smau_pkg::out_item_t                  result,
	input  logic                                 cfg_we,
	input  logic [smau_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [smau_pkg::CNT_BITS-1:0]        cfg_data
);

	import smau_pkg::*;

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;

	dims_t                 dims_q;
	logic                  adv;
	logic                  a_we, b_we, re;
	logic [ADDR_W-1:0]     waddr, a_raddr, b_raddr;
	logic [ELEM_WIDTH-1:0] wdata, a_rdata, b_rdata;
	ctl_t                  ctl_s1;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q.a_rows <= CNT_BITS'(MAX_DIM);
			dims_q.a_cols <= CNT_BITS'(MAX_DIM);
			dims_q.b_rows <= CNT_BITS'(MAX_DIM);
			dims_q.b_cols <= CNT_BITS'(MAX_DIM);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_A_ROWS: dims_q.a_rows <= cfg_data;
				CFG_A_COLS: dims_q.a_cols <= cfg_data;
				CFG_B_ROWS: dims_q.b_rows <= cfg_data;
				CFG_B_COLS: dims_q.b_cols <= cfg_data;
				default:    dims_q        <= dims_q;
			endcase
		end
	end

	smau_seq #(
		.MAX_DIM    (MAX_DIM),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.dims       (dims_q),
		.adv        (adv),
		.a_we       (a_we),
		.b_we       (b_we),
		.waddr      (waddr),
		.wdata      (wdata),
		.re         (re),
		.a_raddr    (a_raddr),
		.b_raddr    (b_raddr),
		.ctl_s1     (ctl_s1)
	);

	smau_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_store_a (
		.clk   (clk),
		.we    (a_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	smau_ram #(
		.WIDTH (ELEM_WIDTH),
		.DEPTH (DEPTH)
	) u_store_b (
		.clk   (clk),
		.we    (b_we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	smau_dp #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_s1       (ctl_s1),
		.a_rdata      (a_rdata),
		.b_rdata      (b_rdata),
		.result_stall (result_stall),
		.adv          (adv),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: rtl/core/smau_checker.sv
// Port-level checks of the matrix arithmetic unit, bound to the top level.
// Depends on smau_pkg and small_matrix_arithmetic_unit_defines.svh.
`include "small_matrix_arithmetic_unit_defines.svh"

module smau_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input smau_pkg::in_item_t  item,
	input logic                result_valid,
	input logic                result_stall,
	input smau_pkg::out_item_t result
);

	import smau_pkg::*;

	logic hold_cond;
	logic err_beat;
	logic err_shape_ok;
	logic compute_beat;

	assign hold_cond    = result_valid && result_stall;
	assign err_beat     = result_valid && result.size_error;
	assign err_shape_ok = result.is_last && (result.out_value == '0)
		&& (result.out_row == '0) && (result.out_col == '0);
	assign compute_beat = item_valid && (item.action == ACT_COMPUTE);

	// A stalled result beat holds
	`SMAU_ASSERT_NEXT(a_result_hold, hold_cond, result_valid && $stable(result), "held beat changed")

	// An error result is a lone zero beat at the origin
	`SMAU_ASSERT_NOW(a_error_shape, err_beat, err_shape_ok, "malformed error result")

	// Only a compute beat makes the block stall its item channel
	`SMAU_ASSERT_NOW(a_stall_cause, $rose(item_stall), $past(compute_beat), "stall without compute")

endmodule

bind small_matrix_arithmetic_unit smau_checker u_smau_checker (.*);

// File: tb/smau_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard of the small matrix arithmetic unit bench: keeps its own copy of
// both element stores and the size registers, predicts every result element.
// Depends on smau_pkg.
package smau_tb_pkg;
	import smau_pkg::*;

	localparam int GRID_DIM = 8;

	class matrix_scoreboard;
		logic signed [IN_ELEM_W-1:0] a_elems [GRID_DIM*GRID_DIM];
		logic signed [IN_ELEM_W-1:0] b_elems [GRID_DIM*GRID_DIM];
		logic [CNT_BITS-1:0] size_regs [4];
		out_item_t expected_elems [$];
		int unsigned mismatch_count;
		int unsigned checked_count;

		function new();
			foreach (size_regs[n]) size_regs[n] = CNT_BITS'(GRID_DIM);
			foreach (a_elems[n]) begin
				a_elems[n] = '0;
				b_elems[n] = '0;
			end
			mismatch_count = 0;
			checked_count = 0;
		endfunction

		function void set_size(cfg_reg_t idx, logic [CNT_BITS-1:0] value);
			size_regs[int'(idx)] = value;
		endfunction

		// Zero counts as one, anything past the grid counts as the full grid
		function int unsigned eff_size(cfg_reg_t idx);
			logic [CNT_BITS-1:0] raw;
			raw = size_regs[int'(idx)];
			if (raw == 0) return 1;
			if (raw > GRID_DIM) return GRID_DIM;
			return raw;
		endfunction

		function longint a_at(int unsigned r, int unsigned c);
			return a_elems[r * GRID_DIM + c];
		endfunction

		function longint b_at(int unsigned r, int unsigned c);
			return b_elems[r * GRID_DIM + c];
		endfunction

		function int pending();
			return expected_elems.size();
		endfunction

		// Apply one accepted item beat: update a store or queue the results
		function void note_item(in_item_t beat);
			int unsigned ar, ac, br, bc, rows, cols, inner;
			int unsigned i, j, k;
			bit shapes_ok;
			longint acc;
			out_item_t elem;
			ar = eff_size(CFG_A_ROWS);
			ac = eff_size(CFG_A_COLS);
			br = eff_size(CFG_B_ROWS);
			bc = eff_size(CFG_B_COLS);
			rows = 0;
			cols = 0;
			inner = 0;
			shapes_ok = 1'b0;
			case (beat.action)
				ACT_WR_A: a_elems[beat.row_index * GRID_DIM + beat.col_index] = beat.element_value;
				ACT_WR_B: b_elems[beat.row_index * GRID_DIM + beat.col_index] = beat.element_value;
				ACT_COMPUTE: begin
					case (beat.operation)
						OP_ADD, OP_SUB: begin
							shapes_ok = (ar == br) && (ac == bc);
							rows = ar;
							cols = ac;
						end
						OP_MUL: begin
							shapes_ok = (ac == br);
							rows = ar;
							cols = bc;
							inner = ac;
						end
						OP_AT_MUL: begin
							shapes_ok = (ar == br);
							rows = ac;
							cols = bc;
							inner = ar;
						end
						OP_MUL_BT: begin
							shapes_ok = (ac == bc);
							rows = ar;
							cols = br;
							inner = ac;
						end
						OP_TRANSPOSE: begin
							shapes_ok = (ar == ac);
							rows = ac;
							cols = ar;
						end
						default: shapes_ok = 1'b0;
					endcase
					if (!shapes_ok) begin
						// Single error beat at position zero
						elem = '0;
						elem.is_last = 1'b1;
						elem.size_error = 1'b1;
						expected_elems.push_back(elem);
					end else begin
						for (i = 0; i < rows; i++) begin
							for (j = 0; j < cols; j++) begin
								acc = 0;
								// Sums are aligned to Q24.16, products already are
								case (beat.operation)
									OP_ADD: acc = (a_at(i, j) + b_at(i, j)) <<< FRAC_SHIFT;
									OP_SUB: acc = (a_at(i, j) - b_at(i, j)) <<< FRAC_SHIFT;
									OP_MUL: for (k = 0; k < inner; k++) acc += a_at(i, k) * b_at(k, j);
									OP_AT_MUL: for (k = 0; k < inner; k++) acc += a_at(k, i) * b_at(k, j);
									OP_MUL_BT: for (k = 0; k < inner; k++) acc += a_at(i, k) * b_at(j, k);
									default: acc = a_at(j, i) <<< FRAC_SHIFT;
								endcase
								elem.out_row = i[IDX_BITS-1:0];
								elem.out_col = j[IDX_BITS-1:0];
								elem.out_value = acc[VALUE_W-1:0];
								elem.is_last = (i + 1 == rows) && (j + 1 == cols);
								elem.size_error = 1'b0;
								expected_elems.push_back(elem);
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			mismatch_count++;
			if (mismatch_count <= 40) $display("MISMATCH: %s", what);
		endtask

		task compare_field(string field, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got %0h, expected %0h",
					checked_count, field, got, want));
		endtask

		// Check one accepted result beat against the oldest prediction
		task check_result(out_item_t got);
			out_item_t want;
			if (expected_elems.size() == 0) begin
				report($sformatf("result beat with nothing pending: row %0d col %0d value %0h",
					got.out_row, got.out_col, got.out_value));
				return;
			end
			want = expected_elems.pop_front();
			checked_count++;
			compare_field("out_row", got.out_row, want.out_row);
			compare_field("out_col", got.out_col, want.out_col);
			compare_field("out_value", got.out_value, want.out_value);
			compare_field("is_last", got.is_last, want.is_last);
			compare_field("size_error", got.size_error, want.size_error);
		endtask
	endclass

endpackage

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the small matrix arithmetic unit bench: clock, reset, item and size
// register drivers, a stalling result sink and the end-of-run verdict.
// Depends on smau_pkg, smau_tb_pkg and small_matrix_arithmetic_unit.
module tb_top;
	import smau_pkg::*;
	import smau_tb_pkg::*;

	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;
	localparam int unsigned RANDOM_ITEMS = 270;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned DRAIN_CYCLES = 30;
	localparam int unsigned CYCLE_LIMIT = 5000000;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	in_item_t item;
	logic result_valid;
	logic result_stall;
	out_item_t result;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CNT_BITS-1:0] cfg_data;

	matrix_scoreboard elem_board;
	bit a_loaded [GRID_DIM*GRID_DIM];
	bit b_loaded [GRID_DIM*GRID_DIM];
	bit quiet_phase;
	bit hold_off_req;
	int unsigned item_total;
	int unsigned cycle_count;

	small_matrix_arithmetic_unit #(
		.MAX_DIM(GRID_DIM),
		.ELEM_WIDTH(IN_ELEM_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Observe both channels at the edge where beats are taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) elem_board.note_item(item);
			if (result_valid && !result_stall) elem_board.check_result(result);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Mostly no idle, often a few cycles, now and then a long stretch
	function automatic int unsigned pick_idle();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic signed [IN_ELEM_W-1:0] rand_element();
		logic signed [IN_ELEM_W-1:0] corners [6];
		corners = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd256, -16'sd256};
		if ($urandom_range(0, 99) < 20) return corners[$urandom_range(0, 5)];
		return IN_ELEM_W'($urandom);
	endfunction

	// Random content in every field, callers overwrite the ones that matter
	function automatic in_item_t rand_beat();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic logic [CNT_BITS-1:0] pick_size();
		logic [CNT_BITS-1:0] size;
		size = ($urandom_range(0, 99) < 85) ? CNT_BITS'($urandom_range(1, 4))
			: CNT_BITS'($urandom_range(5, GRID_DIM));
		if (size == 1 && $urandom_range(0, 1)) size = '0;
		if (size == GRID_DIM && $urandom_range(0, 1)) size = CNT_BITS'($urandom_range(9, 15));
		return size;
	endfunction

	// Offer one beat and hold it until taken; keep valid high when no gap follows
	task automatic send_beat(in_item_t beat);
		int unsigned gap;
		item <= beat;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (beat.action == ACT_WR_A) a_loaded[beat.row_index * GRID_DIM + beat.col_index] = 1'b1;
		if (beat.action == ACT_WR_B) b_loaded[beat.row_index * GRID_DIM + beat.col_index] = 1'b1;
		if (beat.action != ACT_IGNORED) item_total++;
		gap = quiet_phase ? 0 : pick_idle();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_elem(bit to_b, int unsigned r, int unsigned c,
			logic signed [IN_ELEM_W-1:0] value);
		in_item_t beat;
		beat = rand_beat();
		beat.action = to_b ? ACT_WR_B : ACT_WR_A;
		beat.row_index = r[IDX_BITS-1:0];
		beat.col_index = c[IDX_BITS-1:0];
		beat.element_value = value;
		send_beat(beat);
	endtask

	task automatic send_compute(logic [2:0] op);
		in_item_t beat;
		beat = rand_beat();
		beat.action = ACT_COMPUTE;
		beat.operation = op;
		send_beat(beat);
	endtask

	task automatic send_ignored();
		in_item_t beat;
		beat = rand_beat();
		beat.action = ACT_IGNORED;
		send_beat(beat);
	endtask

	// Load every element of the region that a compute will read and is still empty
	task automatic fill_missing(bit to_b, int unsigned rows, int unsigned cols);
		for (int unsigned r = 0; r < rows; r++)
			for (int unsigned c = 0; c < cols; c++)
				if (!(to_b ? b_loaded[r * GRID_DIM + c] : a_loaded[r * GRID_DIM + c]))
					load_elem(to_b, r, c, rand_element());
	endtask

	// Write all four size registers on consecutive edges
	task automatic set_sizes(logic [CNT_BITS-1:0] ar, logic [CNT_BITS-1:0] ac,
			logic [CNT_BITS-1:0] br, logic [CNT_BITS-1:0] bc);
		logic [CNT_BITS-1:0] vals [4];
		cfg_reg_t idx;
		vals = '{ar, ac, br, bc};
		for (int n = 0; n < 4; n++) begin
			idx = cfg_reg_t'(n);
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= vals[n];
			@(posedge clk);
			elem_board.set_size(idx, vals[n]);
		end
		cfg_we <= 1'b0;
	endtask

	// Drop valid, let the last beat reach the scoreboard, then wait out all
	// pending results and the pipeline tail
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (elem_board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly loads into the current shapes followed by a compute, plus noise
	task automatic random_phase(int unsigned budget);
		int unsigned start_total, ar, ac, br, bc, roll, loads;
		bit to_b;
		logic [2:0] op;
		start_total = item_total;
		ar = elem_board.eff_size(CFG_A_ROWS);
		ac = elem_board.eff_size(CFG_A_COLS);
		br = elem_board.eff_size(CFG_B_ROWS);
		bc = elem_board.eff_size(CFG_B_COLS);
		while (item_total - start_total < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				send_ignored();
			end else if (roll < 25) begin
				load_elem(1'($urandom_range(0, 1)), $urandom_range(0, GRID_DIM - 1),
					$urandom_range(0, GRID_DIM - 1), rand_element());
			end else begin
				loads = $urandom_range(0, 3);
				repeat (loads) begin
					to_b = 1'($urandom_range(0, 1));
					if (to_b)
						load_elem(1'b1, $urandom_range(0, br - 1), $urandom_range(0, bc - 1),
							rand_element());
					else
						load_elem(1'b0, $urandom_range(0, ar - 1), $urandom_range(0, ac - 1),
							rand_element());
				end
				fill_missing(1'b0, ar, ac);
				fill_missing(1'b1, br, bc);
				if ($urandom_range(0, 99) < 88)
					op = 3'($urandom_range(OP_ADD, OP_TRANSPOSE));
				else
					op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
				send_compute(op);
			end
		end
	endtask

	// Result sink: random stall stretches, calm in quiet phases, one long hold-off
	initial begin : result_sink
		int unsigned run_len, stall_len;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			run_len = quiet_phase ? 40 : $urandom_range(1, 12);
			result_stall <= 1'b0;
			repeat (run_len) @(posedge clk);
			stall_len = quiet_phase ? 0 : pick_idle();
			if (stall_len != 0) begin
				result_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int unsigned phase, random_start, budget;
		logic [CNT_BITS-1:0] r, c, q;
		elem_board = new();
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_A_ROWS;
		cfg_data <= '0;
		quiet_phase = 1'b0;
		hold_off_req = 1'b0;
		item_total = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 2x2 operands with extreme elements, every operation code
		set_sizes(4'd2, 4'd2, 4'd2, 4'd2);
		load_elem(1'b0, 0, 0, 16'sh8000);
		load_elem(1'b0, 0, 1, 16'sh7fff);
		load_elem(1'b0, 1, 0, -16'sd1);
		load_elem(1'b0, 1, 1, 16'sd0);
		load_elem(1'b1, 0, 0, 16'sh7fff);
		load_elem(1'b1, 0, 1, 16'sh8000);
		load_elem(1'b1, 1, 0, 16'sd256);
		load_elem(1'b1, 1, 1, 16'sh8000);
		send_compute(OP_ADD);
		send_compute(OP_SUB);
		send_compute(OP_MUL);
		send_compute(OP_AT_MUL);
		send_compute(OP_MUL_BT);
		send_compute(OP_TRANSPOSE);
		send_compute(OP_RSVD_6);
		send_compute(OP_RSVD_7);
		send_ignored();
		settle();

		// Directed: A 1x2 against B 2x1, only the product fits
		set_sizes(4'd1, 4'd2, 4'd2, 4'd1);
		send_compute(OP_ADD);
		send_compute(OP_MUL);
		send_compute(OP_TRANSPOSE);
		settle();

		// Random phases, each under its own size setting
		random_start = item_total;
		phase = 1;
		while (item_total - random_start < RANDOM_ITEMS) begin
			case (phase)
				1: set_sizes(4'd0, 4'd0, 4'd0, 4'd0);
				2: set_sizes(4'd15, 4'd15, 4'd15, 4'd15);
				3: set_sizes(4'd8, 4'd1, 4'd1, 4'd8);
				4: set_sizes(4'd1, 4'd8, 4'd8, 4'd1);
				default: begin
					r = pick_size();
					c = pick_size();
					q = pick_size();
					case ($urandom_range(0, 3))
						0: set_sizes(r, c, r, c);
						1: set_sizes(r, c, c, q);
						2: set_sizes(r, r, r, r);
						default: set_sizes(CNT_BITS'($urandom_range(0, 15)),
							CNT_BITS'($urandom_range(0, 15)),
							CNT_BITS'($urandom_range(0, 15)),
							CNT_BITS'($urandom_range(0, 15)));
					endcase
				end
			endcase
			quiet_phase = (phase % 4 == 2);
			if (phase == 5) hold_off_req = 1'b1;
			budget = (elem_board.eff_size(CFG_A_ROWS) > 4 || elem_board.eff_size(CFG_A_COLS) > 4
				|| elem_board.eff_size(CFG_B_ROWS) > 4 || elem_board.eff_size(CFG_B_COLS) > 4)
				? 12 : 30;
			random_phase(budget);
			settle();
			phase++;
		end

		if (elem_board.mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: small_matrix_arithmetic_unit.f
+incdir+rtl/core
rtl/core/smau_pkg.sv
rtl/core/smau_ram.sv
rtl/core/smau_seq.sv
rtl/core/smau_dp.sv
rtl/core/small_matrix_arithmetic_unit.sv
rtl/core/smau_checker.sv
tb/smau_scoreboard_pkg.sv
tb/tb_top.sv
